FILE: hw/rtl/orb_pkg.sv
// ----------------------------------------------------------------------------
// orb_pkg: shared types and constants for the overwriting byte ring buffer
// Sizes, operation codes and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package orb_pkg;

   // buffer geometry
   localparam int DEPTH     = 32;
   localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 6;
   localparam int RUN_LIMIT = 32;
   localparam int CMP_W     = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int SUM_W     = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;

   // operation codes carried on req_cmd
   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2,
      OP_NONE = 2'd3
   } orb_op_type;

   // controller states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } orb_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic push;   // store one byte
      logic load;   // start a read run
      logic pop;    // the run removes its bytes
      logic emit;   // present one result this cycle
   } orb_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic last;   // the result presented now ends the run
   } orb_sts_type;

   // ring pointer increment with wrap
   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

endpackage

FILE: hw/rtl/orb_ram.sv
// ----------------------------------------------------------------------------
// orb_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module orb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/orb_ctrl.sv
// ----------------------------------------------------------------------------
// orb_ctrl: controller for the overwriting byte ring buffer
// Takes commands, sequences read runs and drives the datapath.
// ----------------------------------------------------------------------------
module orb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          req_cmd,
   input  orb_pkg::orb_sts_type sts,
   output orb_pkg::orb_cmd_type ctl,
   output logic                busy
);

   import orb_pkg::*;

   orb_state_type state_ff;
   orb_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      busy     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (orb_op_type'(req_cmd))
                  OP_PUSH: begin
                     ctl.push = 1'b1;
                  end
                  OP_POP: begin
                     ctl.load = 1'b1;
                     ctl.pop  = 1'b1;
                     state_in = ST_RUN;
                  end
                  OP_PEEK: begin
                     ctl.load = 1'b1;
                     state_in = ST_RUN;
                  end
                  default: begin
                     // unused code: no transfer, no state change
                  end
               endcase
            end
         end
         ST_RUN: begin
            busy     = 1'b1;
            ctl.emit = 1'b1;
            if (sts.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/orb_dp.sv
// ----------------------------------------------------------------------------
// orb_dp: datapath for the overwriting byte ring buffer
// Pointers, fill count, run counters and the byte store.
// ----------------------------------------------------------------------------
module orb_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  orb_pkg::orb_cmd_type          ctl,
   output orb_pkg::orb_sts_type          sts,
   input  logic [orb_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic [orb_pkg::LEN_W-1:0]     req_read_length,
   output logic                          rsp_valid,
   output logic [orb_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                          rsp_is_last,
   output logic [orb_pkg::LEN_W-1:0]     rsp_read_count
);

   import orb_pkg::*;

   logic [PTR_W-1:0]  oldest_ff, oldest_in;
   logic [PTR_W-1:0]  newest_ff, newest_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [LEN_W-1:0]  run_len_ff, run_len_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic              empty_ff, empty_in;

   logic [CMP_W-1:0]  len_x;
   logic [CMP_W-1:0]  cnt_x;
   logic [LEN_W-1:0]  take;
   logic [LEN_W-1:0]  n;
   logic [SUM_W-1:0]  adv_sum;
   logic [PTR_W-1:0]  adv_ptr;
   logic [PTR_W-1:0]  rd_addr;
   logic [BYTE_W-1:0] rd_data;

   // run length: request clamped to fill count, then to the run limit
   always_comb begin
      len_x = CMP_W'(req_read_length);
      cnt_x = CMP_W'(count_ff);
      if (cnt_x < len_x) begin
         take = LEN_W'(count_ff);
      end else begin
         take = req_read_length;
      end
      if (take > LEN_W'(RUN_LIMIT)) begin
         n = LEN_W'(RUN_LIMIT);
      end else begin
         n = take;
      end
   end

   // oldest pointer after a pop of n bytes, wrapped once
   always_comb begin
      adv_sum = SUM_W'(oldest_ff) + SUM_W'(n);
      if (adv_sum >= SUM_W'(DEPTH)) begin
         adv_ptr = PTR_W'(adv_sum - SUM_W'(DEPTH));
      end else begin
         adv_ptr = PTR_W'(adv_sum);
      end
   end

   // next state of the ring and run registers
   always_comb begin
      oldest_in  = oldest_ff;
      newest_in  = newest_ff;
      count_in   = count_ff;
      rd_ptr_in  = rd_ptr_ff;
      run_len_in = run_len_ff;
      left_in    = left_ff;
      empty_in   = empty_ff;
      if (ctl.push) begin
         newest_in = ring_next(newest_ff);
         if (count_ff == CNT_W'(DEPTH)) begin
            oldest_in = ring_next(oldest_ff);
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (ctl.load) begin
         rd_ptr_in  = ring_next(oldest_ff);
         run_len_in = n;
         left_in    = n;
         empty_in   = (n == '0);
         if (ctl.pop) begin
            oldest_in = adv_ptr;
            count_in  = count_ff - CNT_W'(n);
         end
      end
      if (ctl.emit) begin
         rd_ptr_in = ring_next(rd_ptr_ff);
         left_in   = left_ff - LEN_W'(1);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         newest_ff <= '0;
         count_ff  <= '0;
      end else begin
         oldest_ff <= oldest_in;
         newest_ff <= newest_in;
         count_ff  <= count_in;
      end
   end

   // run registers, only read while a run is active
   always_ff @(posedge clock) begin
      rd_ptr_ff  <= rd_ptr_in;
      run_len_ff <= run_len_in;
      left_ff    <= left_in;
      empty_ff   <= empty_in;
   end

   // first byte is addressed on the accepting cycle, the rest during the run
   assign rd_addr = ctl.emit ? rd_ptr_ff : oldest_ff;

   orb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ctl.push),
      .wr_addr (newest_ff),
      .wr_data (req_data_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result transfer
   assign sts.last       = empty_ff || (left_ff == LEN_W'(1));
   assign rsp_valid      = ctl.emit;
   assign rsp_out_byte   = empty_ff ? '0 : rd_data;
   assign rsp_is_last    = sts.last;
   assign rsp_read_count = empty_ff ? '0 : run_len_ff;

endmodule

FILE: hw/rtl/overwriting_byte_ring_buffer_core.sv
// ----------------------------------------------------------------------------
// overwriting_byte_ring_buffer_core: byte ring buffer that overwrites oldest
// Push stores a byte; pop and peek stream up to the requested bytes.
//
//   channel   ports                           handshake
//   request   req_cmd, req_data_byte,         start high while busy low
//             req_read_length
//   result    rsp_out_byte, rsp_is_last,      rsp_valid strobe, one cycle
//             rsp_read_count
//
// A push or an unused command starts no run; busy stays low.
// A pop or peek of n bytes keeps busy high while its n results go out (one
// for an empty read), one result per cycle starting the cycle after
// acceptance; the next transfer can be taken in the cycle after the last
// result. The store's registered read port delays the first result.
// Reset is synchronous and clears pointers and fill count; no clearing pass.
// The receiver cannot stall results.
// ----------------------------------------------------------------------------
module overwriting_byte_ring_buffer_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_cmd,
   input  logic [orb_pkg::BYTE_W-1:0] req_data_byte,
   input  logic [orb_pkg::LEN_W-1:0]  req_read_length,
   output logic                       rsp_valid,
   output logic [orb_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                       rsp_is_last,
   output logic [orb_pkg::LEN_W-1:0]  rsp_read_count
);

   import orb_pkg::*;

   orb_cmd_type ctl;
   orb_sts_type sts;

   // sequencing
   orb_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .sts     (sts),
      .ctl     (ctl),
      .busy    (busy)
   );

   // storage and pointers
   orb_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .req_data_byte   (req_data_byte),
      .req_read_length (req_read_length),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_last     (rsp_is_last),
      .rsp_read_count  (rsp_read_count)
   );

endmodule
